FILE: hdl/rau_pkg.sv
package rau_pkg;

    localparam int NumW = 16;
    localparam int DenW = NumW - 1;
    localparam int ResNumW = 32;
    localparam int ResDenW = 30;
    localparam int WideW = 34;
    localparam int CntW = 6;

    typedef enum logic [1:0] {
        OP_ADD = 2'd0,
        OP_SUB = 2'd1,
        OP_MUL = 2'd2,
        OP_DIV = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        CMD_NONE  = 3'd0,
        CMD_LOAD  = 3'd1,
        CMD_GCD1  = 3'd2,
        CMD_SCALE = 3'd3,
        CMD_PREP  = 3'd4,
        CMD_GCD2  = 3'd5,
        CMD_DIVN  = 3'd6,
        CMD_DIVD  = 3'd7
    } t_cmd;

    typedef struct packed {
        logic out_load;
        logic div_step;
        logic gcd_step;
        t_cmd cmd;
    } t_ctrl;

    typedef struct packed {
        logic gcd_done;
        logic div_done;
        logic zero_case;
        logic add_sub;
    } t_stat;

endpackage

FILE: hdl/rational_arithmetic_unit.sv
// Rational arithmetic unit: a_num/a_den op b_num/b_den, result reduced by gcd.
// Input channel: i_valid / o_stall with opcode and both fractions. An item is
// taken when i_valid is high and o_stall low. Output channel: o_valid /
// i_stall with res_num, res_den, div_zero; taken when o_valid and !i_stall.
// One item is in flight at a time; o_stall is high while it is worked on.
// Results sit in an output register, so the next item can start while one
// waits; a finished item waits in its last state until that register frees.
// Each Euclid step is one remainder on the shared divider plus a load step.
// Multiply/divide run the result gcd and then divide out by it; add/sub first
// run the denominator gcd and scale by it. Divide by a zero second numerator
// returns the first fraction without using the divider.
// Reset (synchronous, active low) empties the block; no result is pending.
// When the receiver stalls, the result holds on the output ports.
module rational_arithmetic_unit
    import rau_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_stall,
    input  logic [1:0]                i_opcode,
    input  logic signed [NumW-1:0]    i_a_num,
    input  logic [DenW-1:0]           i_a_den,
    input  logic signed [NumW-1:0]    i_b_num,
    input  logic [DenW-1:0]           i_b_den,
    output logic                      o_valid,
    input  logic                      i_stall,
    output logic signed [ResNumW-1:0] o_res_num,
    output logic [ResDenW-1:0]        o_res_den,
    output logic                      o_div_zero
);

    t_ctrl w_ctrl;
    t_stat w_stat;

    rau_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .i_stat  (w_stat),
        .o_ctrl  (w_ctrl)
    );

    rau_datapath u_dp (
        .i_clk      (i_clk),
        .i_ctrl     (w_ctrl),
        .i_opcode   (i_opcode),
        .i_a_num    (i_a_num),
        .i_a_den    (i_a_den),
        .i_b_num    (i_b_num),
        .i_b_den    (i_b_den),
        .o_stat     (w_stat),
        .o_res_num  (o_res_num),
        .o_res_den  (o_res_den),
        .o_div_zero (o_div_zero)
    );

endmodule

FILE: hdl/rau_datapath.sv
module rau_datapath
    import rau_pkg::*;
(
    input  logic                      i_clk,
    input  t_ctrl                     i_ctrl,
    input  logic [1:0]                i_opcode,
    input  logic signed [NumW-1:0]    i_a_num,
    input  logic [DenW-1:0]           i_a_den,
    input  logic signed [NumW-1:0]    i_b_num,
    input  logic [DenW-1:0]           i_b_den,
    output t_stat                     o_stat,
    output logic signed [ResNumW-1:0] o_res_num,
    output logic [ResDenW-1:0]        o_res_den,
    output logic                      o_div_zero
);

    logic [1:0]             r_op;
    logic signed [NumW-1:0] r_an, r_bn;
    logic [DenW-1:0]        r_ad, r_bd;
    logic [WideW-1:0]       r_gx, r_gy;
    logic [WideW-1:0]       r_mag, r_den;
    logic                   r_neg;
    logic [WideW-1:0]       r_q, r_rem, r_dvd, r_dvs;
    logic [CntW-1:0]        r_cnt;
    logic                   r_zero;
    logic [WideW-1:0]       r_fa;
    logic signed [ResNumW-1:0] r_res_num;
    logic [ResDenW-1:0]     r_res_den;
    logic                   r_res_dz;

    logic [WideW:0]         w_sub;
    logic [WideW-1:0]       w_rem_sh;
    logic signed [WideW-1:0] w_ta, w_tb, w_sum;

    assign w_rem_sh = {r_rem[WideW-2:0], r_dvd[WideW-1]};
    assign w_sub = {1'b0, w_rem_sh} - {1'b0, r_dvs};
    assign w_ta = WideW'(r_an) * $signed({1'b0, r_fa[DenW-1:0]});
    assign w_tb = WideW'(r_bn) * $signed({1'b0, r_q[DenW-1:0]});
    assign w_sum = (r_op == OP_ADD) ? w_ta + w_tb : w_ta - w_tb;

    always_comb begin
        o_stat.gcd_done = (r_gx == '0);
        o_stat.div_done = (r_cnt == '0);
        o_stat.zero_case = (r_op == OP_DIV) && (r_bn == '0);
        o_stat.add_sub = (r_op == OP_ADD) || (r_op == OP_SUB);
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.div_step || (i_ctrl.gcd_step && r_cnt != '0)) begin
            r_dvd <= {r_dvd[WideW-2:0], 1'b0};
            r_cnt <= r_cnt - 1'b1;
            if (!w_sub[WideW]) begin
                r_rem <= w_sub[WideW-1:0];
                r_q <= {r_q[WideW-2:0], 1'b1};
            end else begin
                r_rem <= w_rem_sh;
                r_q <= {r_q[WideW-2:0], 1'b0};
            end
        end else if (i_ctrl.gcd_step) begin
            r_dvd <= r_gy;
            r_dvs <= r_gx;
            r_rem <= '0;
            r_cnt <= CntW'(WideW);
        end
        case (i_ctrl.cmd)
            CMD_LOAD: begin
                r_op <= i_opcode;
                r_an <= i_a_num;
                r_bn <= i_b_num;
                r_ad <= (i_a_den == '0) ? DenW'(1) : i_a_den;
                r_bd <= (i_b_den == '0) ? DenW'(1) : i_b_den;
                r_cnt <= '0;
                r_zero <= 1'b0;
            end
            CMD_GCD1: begin
                r_gx <= WideW'(r_ad);
                r_gy <= WideW'(r_bd);
            end
            CMD_SCALE: begin
                r_dvd <= WideW'(r_bd);
                r_den <= WideW'(r_ad);
                r_dvs <= r_gy;
                r_rem <= '0;
                r_cnt <= CntW'(WideW);
            end
            CMD_PREP: begin
                r_zero <= 1'b0;
                case (r_op)
                    OP_ADD, OP_SUB: begin
                        r_neg <= w_sum[WideW-1];
                        r_mag <= w_sum[WideW-1] ? -w_sum : w_sum;
                        r_den <= WideW'(r_ad) * WideW'(r_fa[DenW-1:0]);
                    end
                    OP_MUL: begin
                        r_neg <= r_an[NumW-1] ^ r_bn[NumW-1];
                        r_mag <= WideW'(r_an[NumW-1] ? -WideW'(r_an) : WideW'(r_an))
                            * WideW'(r_bn[NumW-1] ? -WideW'(r_bn) : WideW'(r_bn));
                        r_den <= WideW'(r_ad) * WideW'(r_bd);
                    end
                    default: begin
                        r_neg <= r_an[NumW-1] ^ r_bn[NumW-1];
                        r_mag <= WideW'(r_an[NumW-1] ? -WideW'(r_an) : WideW'(r_an))
                            * WideW'(r_bd);
                        r_den <= WideW'(r_ad)
                            * WideW'(r_bn[NumW-1] ? -WideW'(r_bn) : WideW'(r_bn));
                    end
                endcase
            end
            CMD_GCD2: begin
                r_gx <= r_mag;
                r_gy <= r_den;
            end
            CMD_DIVN: begin
                r_dvd <= r_mag;
                r_dvs <= (r_gy == '0) ? WideW'(1) : r_gy;
                r_rem <= '0;
                r_cnt <= CntW'(WideW);
            end
            CMD_DIVD: begin
                r_fa <= r_q;
                r_dvd <= r_den;
                r_rem <= '0;
                r_cnt <= CntW'(WideW);
            end
            default: ;
        endcase
        if (i_ctrl.gcd_step && r_cnt == CntW'(1)) begin
            r_gy <= r_gx;
            r_gx <= w_sub[WideW] ? w_rem_sh : w_sub[WideW-1:0];
        end
        if (i_ctrl.cmd == CMD_NONE && !i_ctrl.div_step && !i_ctrl.gcd_step
                && o_stat.zero_case && r_cnt == '0) begin
            r_zero <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.out_load) begin
            if (r_zero) begin
                r_res_num <= ResNumW'(r_an);
                r_res_den <= ResDenW'(r_ad);
            end else begin
                r_res_num <= r_neg ? -ResNumW'(r_fa) : ResNumW'(r_fa);
                r_res_den <= ResDenW'(r_q);
            end
            r_res_dz <= r_zero;
        end
    end

    assign o_res_num = r_res_num;
    assign o_res_den = r_res_den;
    assign o_div_zero = r_res_dz;

endmodule

FILE: hdl/rau_ctrl.sv
module rau_ctrl
    import rau_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    output logic  o_stall,
    output logic  o_valid,
    input  logic  i_stall,
    input  t_stat i_stat,
    output t_ctrl o_ctrl
);

    typedef enum logic [3:0] {
        S_IDLE, S_CHK, S_G1, S_G1RUN, S_SCALE, S_FB, S_PREP, S_G2, S_G2RUN,
        S_DN, S_DNRUN, S_DD, S_DDRUN, S_OUT
    } t_state;

    t_state r_state;
    logic   r_valid;
    logic   r_fb_pass;

    assign o_stall = (r_state != S_IDLE);
    assign o_valid = r_valid;

    always_comb begin
        o_ctrl = '{out_load: 1'b0, div_step: 1'b0, gcd_step: 1'b0, cmd: CMD_NONE};
        case (r_state)
            S_IDLE:   if (i_valid) o_ctrl.cmd = CMD_LOAD;
            S_G1:     o_ctrl.cmd = CMD_GCD1;
            S_G1RUN, S_G2RUN: o_ctrl.gcd_step = !i_stat.gcd_done;
            S_SCALE:  o_ctrl.cmd = CMD_SCALE;
            S_FB:     o_ctrl.cmd = CMD_DIVD;
            S_PREP:   o_ctrl.cmd = CMD_PREP;
            S_G2:     o_ctrl.cmd = CMD_GCD2;
            S_DN:     o_ctrl.cmd = CMD_DIVN;
            S_DD:     o_ctrl.cmd = CMD_DIVD;
            S_DNRUN, S_DDRUN: o_ctrl.div_step = !i_stat.div_done;
            S_OUT:    o_ctrl.out_load = !r_valid || !i_stall;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
            r_fb_pass <= 1'b0;
        end else begin
            if (o_ctrl.out_load) begin
                r_valid <= 1'b1;
            end else if (!i_stall) begin
                r_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE:   if (i_valid) r_state <= S_CHK;
                S_CHK: begin
                    if (i_stat.zero_case) begin
                        r_state <= S_OUT;
                    end else if (i_stat.add_sub) begin
                        r_state <= S_G1;
                    end else begin
                        r_state <= S_PREP;
                    end
                end
                S_G1:     r_state <= S_G1RUN;
                S_G1RUN:  if (i_stat.gcd_done) r_state <= S_SCALE;
                S_SCALE: begin
                    r_fb_pass <= 1'b1;
                    r_state <= S_DNRUN;
                end
                S_FB:     r_state <= S_DDRUN;
                S_PREP:   r_state <= S_G2;
                S_G2:     r_state <= S_G2RUN;
                S_G2RUN:  if (i_stat.gcd_done) r_state <= S_DN;
                S_DN:     r_state <= S_DNRUN;
                S_DNRUN:  if (i_stat.div_done) r_state <= S_DD;
                S_DD:     r_state <= S_DDRUN;
                S_DDRUN: begin
                    if (i_stat.div_done) begin
                        if (r_fb_pass) begin
                            r_fb_pass <= 1'b0;
                            r_state <= S_PREP;
                        end else begin
                            r_state <= S_OUT;
                        end
                    end
                end
                S_OUT:    if (!r_valid || !i_stall) r_state <= S_IDLE;
                default:  r_state <= S_IDLE;
            endcase
        end
    end

    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> o_stall)
        else $error("accept while busy");
    a_valid_after_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT && (!r_valid || !i_stall)) |=> r_valid)
        else $error("result lost");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && i_stall) |=> r_valid)
        else $error("result dropped under stall");

endmodule

FILE: test/rau_checker.sv
`timescale 1ns / 1ps

module rau_checker
    import rau_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    input  logic                      i_in_stall,
    input  logic [1:0]                i_opcode,
    input  logic signed [NumW-1:0]    i_a_num,
    input  logic [DenW-1:0]           i_a_den,
    input  logic signed [NumW-1:0]    i_b_num,
    input  logic [DenW-1:0]           i_b_den,
    input  logic                      i_out_valid,
    input  logic                      i_out_stall,
    input  logic signed [ResNumW-1:0] i_res_num,
    input  logic [ResDenW-1:0]        i_res_den,
    input  logic                      i_div_zero,
    output int                        o_errors,
    output int                        o_pending
);

    typedef struct packed {
        logic [ResNumW-1:0] num;
        logic [ResDenW-1:0] den;
        logic               dz;
    } t_frac;

    t_frac fractions_due[$];

    function automatic logic [63:0] gcd64(logic [63:0] x, logic [63:0] y);
        logic [63:0] t;
        while (x != 0) begin
            t = y % x;
            y = x;
            x = t;
        end
        return y;
    endfunction

    function automatic t_frac reduce(logic [63:0] num, logic [63:0] den);
        t_frac r;
        logic neg;
        logic [63:0] mag;
        logic [63:0] g;
        logic [63:0] rn;
        neg = num[63];
        mag = neg ? -num : num;
        g = gcd64(mag, den);
        if (g == 0) g = 1;
        rn = mag / g;
        if (neg) rn = -rn;
        r.num = rn[ResNumW-1:0];
        r.den = ResDenW'(den / g);
        r.dz = 1'b0;
        return r;
    endfunction

    function automatic t_frac combine(t_op op, logic signed [NumW-1:0] an_i,
                                      logic [DenW-1:0] ad_i,
                                      logic signed [NumW-1:0] bn_i,
                                      logic [DenW-1:0] bd_i);
        logic [63:0] an, ad, bn, bd, g, fa, fb, ta, tb, num, bmag;
        t_frac r;
        an = 64'(an_i);
        bn = 64'(bn_i);
        ad = (ad_i == 0) ? 64'd1 : 64'(ad_i);
        bd = (bd_i == 0) ? 64'd1 : 64'(bd_i);
        case (op)
            OP_ADD, OP_SUB: begin
                g = gcd64(ad, bd);
                fa = bd / g;
                fb = ad / g;
                ta = an * fa;
                tb = bn * fb;
                r = reduce(op == OP_ADD ? ta + tb : ta - tb, ad * fa);
            end
            OP_MUL: r = reduce(an * bn, ad * bd);
            default: begin
                if (bn == 0) begin
                    r.num = an[ResNumW-1:0];
                    r.den = ad[ResDenW-1:0];
                    r.dz = 1'b1;
                end else begin
                    bmag = bn[63] ? -bn : bn;
                    num = an * bd;
                    if (bn[63]) num = -num;
                    r = reduce(num, ad * bmag);
                end
            end
        endcase
        return r;
    endfunction

    initial o_errors = 0;
    assign o_pending = fractions_due.size();

    always @(posedge i_clk) begin
        t_frac e;
        if (i_rst_n && i_valid && !i_in_stall)
            fractions_due.push_back(combine(t_op'(i_opcode), i_a_num, i_a_den,
                                            i_b_num, i_b_den));
        if (i_rst_n && i_out_valid && !i_out_stall) begin
            if (fractions_due.size() == 0) begin
                o_errors <= o_errors + 1;
                if (o_errors < 10) $display("unexpected result %0d/%0d dz=%0b",
                                            i_res_num, i_res_den, i_div_zero);
            end else begin
                e = fractions_due.pop_front();
                if (e.num !== i_res_num || e.den !== i_res_den
                    || e.dz !== i_div_zero) begin
                    o_errors <= o_errors + 1;
                    if (o_errors < 10)
                        $display("mismatch: expected %0d/%0d dz=%0b, got %0d/%0d dz=%0b",
                                 $signed(e.num), e.den, e.dz,
                                 i_res_num, i_res_den, i_div_zero);
                end
            end
        end
    end

endmodule

FILE: test/tb_rational_arithmetic_unit.sv
`timescale 1ns / 1ps

module tb_rational_arithmetic_unit;
    import rau_pkg::*;

    logic i_clk, i_rst_n, i_valid, o_stall, o_valid, i_stall, o_div_zero;
    logic [1:0] i_opcode;
    logic signed [NumW-1:0] i_a_num, i_b_num;
    logic [DenW-1:0] i_a_den, i_b_den;
    logic signed [ResNumW-1:0] o_res_num;
    logic [ResDenW-1:0] o_res_den;
    int errors, pending, send_idle, recv_stall, cycles;

    rational_arithmetic_unit i_dut (.*);

    rau_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .i_in_stall(o_stall),
        .i_opcode(i_opcode), .i_a_num(i_a_num), .i_a_den(i_a_den),
        .i_b_num(i_b_num), .i_b_den(i_b_den), .i_out_valid(o_valid),
        .i_out_stall(i_stall), .i_res_num(o_res_num), .i_res_den(o_res_den),
        .i_div_zero(o_div_zero), .o_errors(errors), .o_pending(pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        cycles = 0;
        forever begin
            @(posedge i_clk);
            cycles++;
            if (cycles > 20000000) begin
                $display("rational_arithmetic_unit verification failed");
                $finish;
            end
        end
    end

    always @(negedge i_clk) begin
        i_stall <= ($urandom_range(99) < recv_stall);
    end

    function automatic logic [NumW-1:0] rand_num();
        case ($urandom_range(5))
            0: return 16'h8000;
            1: return 16'h7fff;
            2: return 16'(0);
            3: return 16'($urandom_range(20)) - 16'd10;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [DenW-1:0] rand_den();
        case ($urandom_range(5))
            0: return 15'h7fff;
            1: return 15'd1;
            2: return 15'd0;
            3: return 15'($urandom_range(12, 1));
            default: return 15'($urandom);
        endcase
    endfunction

    task automatic send(t_op op, logic [NumW-1:0] an, logic [DenW-1:0] ad,
                        logic [NumW-1:0] bn, logic [DenW-1:0] bd);
        while ($urandom_range(99) < send_idle) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_opcode <= op;
        i_a_num <= an;
        i_a_den <= ad;
        i_b_num <= bn;
        i_b_den <= bd;
        do @(posedge i_clk); while (o_stall);
        @(negedge i_clk);
    endtask

    initial begin
        t_op op;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_stall = 1'b0;
        i_opcode = OP_ADD;
        i_a_num = '0;
        i_a_den = 15'd1;
        i_b_num = '0;
        i_b_den = 15'd1;
        send_idle = 0;
        recv_stall = 0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        send(OP_ADD, 16'h7fff, 15'h7fff, 16'h7fff, 15'h7ffe);
        send(OP_ADD, 16'h8000, 15'd1, 16'h8000, 15'd1);
        send(OP_SUB, 16'h7fff, 15'd3, 16'h8000, 15'd5);
        send(OP_SUB, 16'd5, 15'd7, 16'd5, 15'd7);
        send(OP_MUL, 16'h8000, 15'h7fff, 16'h8000, 15'h7ffd);
        send(OP_MUL, 16'd0, 15'd9, 16'hffff, 15'd4);
        send(OP_MUL, 16'd6, 15'd4, 16'd2, 15'd3);
        send(OP_DIV, 16'd7, 15'd0, 16'd0, 15'd5);
        send(OP_DIV, 16'd6, 15'd4, 16'd0, 15'd3);
        send(OP_DIV, 16'h8000, 15'h7fff, 16'h8000, 15'h7fff);
        send(OP_DIV, 16'd3, 15'd4, 16'hfffd, 15'd8);
        send(OP_ADD, 16'd1, 15'd0, 16'hffff, 15'd0);
        send(OP_SUB, 16'hffff, 15'h5555, 16'h5555, 15'h2aaa);
        send(OP_MUL, 16'h5555, 15'h2aaa, 16'haaaa, 15'h5555);

        for (int i = 0; i < 1540; i++) begin
            case (i / 385)
                0: begin send_idle = 0;  recv_stall = 0;  end
                1: begin send_idle = 74; recv_stall = 0;  end
                2: begin send_idle = 0;  recv_stall = 74; end
                default: begin send_idle = 20; recv_stall = 20; end
            endcase
            op = t_op'($urandom_range(3));
            send(op, rand_num(), rand_den(), rand_num(), rand_den());
        end

        i_valid <= 1'b0;
        send_idle = 0;
        while (pending != 0) @(posedge i_clk);
        repeat (400) @(posedge i_clk);
        if (errors == 0)
            $display("rational_arithmetic_unit verification clean");
        else
            $display("rational_arithmetic_unit verification failed");
        $finish;
    end

endmodule
